/* rtl/core/button_debounce_long_press_defines.svh */
// ----------------------------------------------------------------------------
// Button debounce assertion macros
// Shared concurrent assertion helpers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_DEFINES_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define BDLP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define BDLP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BDLP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define BDLP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

/* rtl/core/bdlp_pkg.sv */
// ----------------------------------------------------------------------------
// Button debounce package
// Types, register indexes and reset values shared by the debounce block.
// ----------------------------------------------------------------------------
package bdlp_pkg;

  localparam int unsigned DEF_TIME_WIDTH = 32;
  localparam int unsigned NOW_W          = 32;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 16;
  localparam int unsigned MS_W           = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LEVEL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TIME   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_TIME = 2'd2;

  localparam logic            RST_ACTIVE_LEVEL    = 1'b0;
  localparam logic [MS_W-1:0] RST_DEBOUNCE_TIME   = 16'd20;
  localparam logic [MS_W-1:0] RST_LONG_PRESS_TIME = 16'd1000;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2,
    EV_LONG    = 2'd3
  } event_e;

  typedef struct packed {
    logic            active_level;
    logic [MS_W-1:0] debounce_time;
    logic [MS_W-1:0] long_press_time;
  } cfg_t;

endpackage

/* rtl/core/button_debounce_long_press.sv */
// ----------------------------------------------------------------------------
// Button debounce with long-press detection
// Debounces polled pin samples and reports press, release and long press.
// ----------------------------------------------------------------------------
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  in      | in_valid_i/in_ready_o, now_time_i,    | sink
//          | pin_level_i                           |
//  out     | out_valid_o/out_ready_i, event_code_o,| source
//          | is_pressed_o                          |
//  cfg     | cfg_valid_i/cfg_ready_o, cfg_index_i, | sink
//          | cfg_data_i                            |
//
// One poll beat per cycle while the sink takes results; an input beat passes
// through the input register, then the state update into the result register.
// Reset puts the button at released level (inverse of the reset active
// level); no pin is read. A stalled result holds the result register and,
// one beat later, the input register; in_ready_o then drops.
// Config writes are always ready; unknown indexes are dropped.
// ----------------------------------------------------------------------------
`include "button_debounce_long_press_defines.svh"

module button_debounce_long_press
  import bdlp_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = DEF_TIME_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // poll input
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [NOW_W-1:0]      now_time_i,
  input  logic                  pin_level_i,
  // result output
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            event_code_o,
  output logic                  is_pressed_o,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg;

  // input register
  logic                  s1_valid_q, s1_valid_d;
  logic [TIME_WIDTH-1:0] s1_now_q;
  logic                  s1_pin_q;

  logic   out_can_load;
  logic   advance;
  logic   in_fire;
  event_e step_event;
  logic   step_pressed;
  event_e out_event;

  assign cfg_ready_o = 1'b1;

  bdlp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // the input stage moves on whenever the result register can take a beat
  assign advance    = s1_valid_q && out_can_load;
  assign in_ready_o = !s1_valid_q || out_can_load;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // timestamp taken modulo 2^TIME_WIDTH
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_now_q <= TIME_WIDTH'(now_time_i);
      s1_pin_q <= pin_level_i;
    end
  end

  bdlp_step #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (advance),
    .now_i     (s1_now_q),
    .pin_i     (s1_pin_q),
    .cfg_i     (cfg),
    .event_o   (step_event),
    .pressed_o (step_pressed)
  );

  bdlp_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .event_i     (step_event),
    .pressed_i   (step_pressed),
    .can_load_o  (out_can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .event_o     (out_event),
    .pressed_o   (is_pressed_o)
  );

  assign event_code_o = out_event;

  // back-pressure only when both stages hold a beat
  `BDLP_ASSERT_NOW(a_stall_full, clk_i, rst_ni,
    !in_ready_o, s1_valid_q && out_valid_o, "input stalled with a free stage")
  // a beat in the input register that cannot move stays put
  `BDLP_ASSERT_NXT(a_s1_hold, clk_i, rst_ni,
    s1_valid_q && !out_can_load,
    s1_valid_q && $stable(s1_now_q) && $stable(s1_pin_q), "input beat lost")

endmodule

/* rtl/core/bdlp_cfg.sv */
// ----------------------------------------------------------------------------
// Button debounce configuration registers
// Holds active level, debounce time and long-press time.
// ----------------------------------------------------------------------------
module bdlp_cfg
  import bdlp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ACTIVE_LEVEL:    cfg_d.active_level    = cfg_data_i[0];
        CFG_DEBOUNCE_TIME:   cfg_d.debounce_time   = cfg_data_i[MS_W-1:0];
        CFG_LONG_PRESS_TIME: cfg_d.long_press_time = cfg_data_i[MS_W-1:0];
        default:             cfg_d = cfg_q;  // unknown index: dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_level    <= RST_ACTIVE_LEVEL;
      cfg_q.debounce_time   <= RST_DEBOUNCE_TIME;
      cfg_q.long_press_time <= RST_LONG_PRESS_TIME;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/bdlp_step.sv */
// ----------------------------------------------------------------------------
// Button debounce step logic
// Debounce and long-press state with the per-poll update.
// ----------------------------------------------------------------------------
`include "button_debounce_long_press_defines.svh"

module bdlp_step
  import bdlp_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = DEF_TIME_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  logic [TIME_WIDTH-1:0] now_i,
  input  logic                  pin_i,
  input  cfg_t                  cfg_i,
  output event_e                event_o,
  output logic                  pressed_o
);

  // compare width covers both the elapsed time and the 16-bit limits
  localparam int unsigned CW = (TIME_WIDTH > MS_W) ? TIME_WIDTH : MS_W;

  logic                  stable_q, stable_d;
  logic                  last_q, last_d;
  logic [TIME_WIDTH-1:0] change_q, change_d;
  logic [TIME_WIDTH-1:0] press_q, press_d;
  logic                  long_rep_q, long_rep_d;

  logic [TIME_WIDTH-1:0] since_chg, since_press;
  logic                  take, long_hit;
  event_e                event_d;

  always_comb begin
    last_d     = pin_i;
    change_d   = (pin_i != last_q) ? now_i : change_q;
    since_chg  = now_i - change_d;
    since_press = now_i - press_q;

    take = (pin_i != stable_q) &&
           (CW'(since_chg) >= CW'(cfg_i.debounce_time));
    long_hit = (stable_q == cfg_i.active_level) &&
               (cfg_i.long_press_time != '0) && !long_rep_q &&
               (CW'(since_press) >= CW'(cfg_i.long_press_time));

    stable_d   = stable_q;
    press_d    = press_q;
    long_rep_d = long_rep_q;
    event_d    = EV_NONE;
    if (take) begin
      stable_d = pin_i;
      if (pin_i == cfg_i.active_level) begin
        press_d    = now_i;
        long_rep_d = 1'b0;
        event_d    = EV_PRESS;
      end else begin
        event_d = EV_RELEASE;
      end
    end else if (long_hit) begin
      long_rep_d = 1'b1;
      event_d    = EV_LONG;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q   <= ~RST_ACTIVE_LEVEL;
      last_q     <= ~RST_ACTIVE_LEVEL;
      change_q   <= '0;
      press_q    <= '0;
      long_rep_q <= 1'b0;
    end else if (fire_i) begin
      stable_q   <= stable_d;
      last_q     <= last_d;
      change_q   <= change_d;
      press_q    <= press_d;
      long_rep_q <= long_rep_d;
    end
  end

  assign event_o   = event_d;
  assign pressed_o = (stable_d == cfg_i.active_level);

  // an edge event always leaves the accepted level at the sampled pin
  `BDLP_ASSERT_NXT(a_edge_takes_pin, clk_i, rst_ni,
    fire_i && (event_d == EV_PRESS || event_d == EV_RELEASE),
    stable_q == $past(pin_i), "edge event without level update")
  // a long press is reported once until the next press
  `BDLP_ASSERT_NXT(a_long_once, clk_i, rst_ni,
    fire_i && event_d == EV_LONG, long_rep_q, "long press not latched")

endmodule

/* rtl/core/bdlp_out.sv */
// ----------------------------------------------------------------------------
// Button debounce result register
// Holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module bdlp_out
  import bdlp_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   load_i,
  input  event_e event_i,
  input  logic   pressed_i,
  output logic   can_load_o,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output event_e event_o,
  output logic   pressed_o
);

  logic   valid_q, valid_d;
  event_e event_q;
  logic   pressed_q;

  assign can_load_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      event_q   <= event_i;
      pressed_q <= pressed_i;
    end
  end

  assign out_valid_o = valid_q;
  assign event_o     = event_q;
  assign pressed_o   = pressed_q;

endmodule

/* dv/bdlp_poll_checker.sv */
// ----------------------------------------------------------------------------
// Button debounce poll checker
// Watches the poll, result and register channels, keeps its own debounce and
// long-press state, and compares every result beat against the prediction.
// ----------------------------------------------------------------------------
module bdlp_poll_checker
  import bdlp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [NOW_W-1:0]      now_time_i,
  input  logic                  pin_level_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [1:0]            event_code_i,
  input  logic                  is_pressed_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    pending_o,
  output int                    err_count_o
);

  typedef struct packed {
    event_e code;
    logic   pressed;
  } poll_result_t;

  poll_result_t due_events[$];

  // register copy
  logic            act_lvl;
  logic [MS_W-1:0] db_ms;
  logic [MS_W-1:0] lp_ms;

  // debounce state
  logic             stable_q;
  logic             sample_q;
  logic [NOW_W-1:0] change_t;
  logic [NOW_W-1:0] press_t;
  logic             long_done;

  task automatic report_mismatch(input string what);
    err_count_o++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_ACTIVE_LEVEL:    act_lvl = data[0];
      CFG_DEBOUNCE_TIME:   db_ms   = data[MS_W-1:0];
      CFG_LONG_PRESS_TIME: lp_ms   = data[MS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic debounce_poll(input logic [NOW_W-1:0] now, input logic lvl);
    poll_result_t     res;
    logic [NOW_W-1:0] held_ms;
    logic [NOW_W-1:0] down_ms;
    res.code = EV_NONE;
    if (lvl != sample_q) begin
      sample_q = lvl;
      change_t = now;
    end
    // both elapsed times wrap modulo 2^32
    held_ms = now - change_t;
    down_ms = now - press_t;
    if (lvl != stable_q && held_ms >= NOW_W'(db_ms)) begin
      stable_q = lvl;
      if (lvl == act_lvl) begin
        press_t   = now;
        long_done = 1'b0;
        res.code  = EV_PRESS;
      end else begin
        res.code = EV_RELEASE;
      end
    end else if (stable_q == act_lvl && lp_ms != '0 && !long_done &&
                 down_ms >= NOW_W'(lp_ms)) begin
      long_done = 1'b1;
      res.code  = EV_LONG;
    end
    res.pressed = (stable_q == act_lvl);
    due_events.push_back(res);
  endtask

  task automatic check_result();
    poll_result_t want;
    if (due_events.size() == 0) begin
      report_mismatch($sformatf("result beat with no poll pending (event %0d, pressed %0b)",
                                event_code_i, is_pressed_i));
    end else begin
      want = due_events.pop_front();
      if (event_code_i !== want.code)
        report_mismatch($sformatf("event_code got %0d want %0d", event_code_i, want.code));
      if (is_pressed_i !== want.pressed)
        report_mismatch($sformatf("is_pressed got %0b want %0b", is_pressed_i, want.pressed));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_lvl     = RST_ACTIVE_LEVEL;
      db_ms       = RST_DEBOUNCE_TIME;
      lp_ms       = RST_LONG_PRESS_TIME;
      stable_q    = ~RST_ACTIVE_LEVEL;
      sample_q    = ~RST_ACTIVE_LEVEL;
      change_t    = '0;
      press_t     = '0;
      long_done   = 1'b0;
      err_count_o = 0;
      due_events.delete();
      pending_o   = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) apply_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_i) debounce_poll(now_time_i, pin_level_i);
      if (out_valid_i && out_ready_i) check_result();
      pending_o = due_events.size();
    end
  end

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// Button debounce testbench
// Drives polls and register writes into the debounce block, with random
// gaps on both channels; a side checker predicts and compares each result.
// ----------------------------------------------------------------------------
module testbench;
  import bdlp_pkg::*;

  localparam int                   CYCLE_LIMIT    = 400000;
  localparam int                   PHASES         = 6;
  localparam int                   RANDOM_POLLS   = 1350;
  localparam int                   SINK_HOLD      = 64;   // long receiver stall
  localparam int                   DRAIN_CYCLES   = 4;    // pipeline is two deep
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [NOW_W-1:0]      now_time_i;
  logic                  pin_level_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [1:0]            event_code_o;
  logic                  is_pressed_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int pending;
  int err_count;

  // stimulus-side bookkeeping
  logic             calm;             // no idling on either side while set
  int               holds_requested;  // bumped to ask the sink for a long stall
  int               polls_sent;
  logic [NOW_W-1:0] clock_ms;         // running millisecond time base
  logic             cur_act;
  int unsigned      cur_db;
  int unsigned      cur_lp;

  button_debounce_long_press i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .now_time_i  (now_time_i),
    .pin_level_i (pin_level_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .event_code_o(event_code_o),
    .is_pressed_o(is_pressed_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  bdlp_poll_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .now_time_i  (now_time_i),
    .pin_level_i (pin_level_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .event_code_i(event_code_o),
    .is_pressed_i(is_pressed_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pending_o   (pending),
    .err_count_o (err_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case a handshake never completes.
  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still due", cycle_count, pending);
    $display("end of test: mismatches");
    $finish;
  end

  // Idle cycles before the next beat on either side.
  function automatic int unsigned pick_gap();
    return calm ? 0 : $urandom_range(0, 5);
  endfunction

  // One poll beat. Entered and left at a falling edge; valid stays high
  // across back-to-back beats so it is never dropped and raised in one step.
  task automatic send_poll(input logic [NOW_W-1:0] t, input logic lvl);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    now_time_i  <= t;
    pin_level_i <= lvl;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    polls_sent++;
    @(negedge clk_i);
  endtask

  // Stop offering polls until every result is back, then let the
  // pipeline go quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    @(negedge clk_i);
  endtask

  // Reprogram all registers while the block is idle. A write to the unused
  // index goes first and must be dropped; active_level gets junk in the
  // upper data bits.
  task automatic program_regs(input logic act, input logic [MS_W-1:0] db,
                              input logic [MS_W-1:0] lp);
    settle();
    write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom));
    write_reg(CFG_ACTIVE_LEVEL, {15'($urandom), act});
    write_reg(CFG_DEBOUNCE_TIME, db);
    write_reg(CFG_LONG_PRESS_TIME, lp);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
    cur_act = act;
    cur_db  = 32'(db);
    cur_lp  = 32'(lp);
  endtask

  // Keep one level for at least span ms after its first poll; steps are
  // random and sometimes land exactly on the span.
  task automatic hold_level(input logic lvl, input int unsigned span);
    int unsigned acc;
    int unsigned step;
    clock_ms += NOW_W'($urandom_range(0, 3));
    send_poll(clock_ms, lvl);
    acc = 0;
    while (acc < span) begin
      step = $urandom_range(0, span / 2 + 1);
      if (acc + step > span && $urandom_range(0, 1) == 1) step = span - acc;
      clock_ms += step;
      acc += step;
      send_poll(clock_ms, lvl);
    end
  endtask

  // Contact bounce: a few quick alternating samples.
  task automatic bounce(input int unsigned n);
    logic lvl;
    lvl = 1'($urandom);
    repeat (n) begin
      clock_ms += NOW_W'($urandom_range(0, cur_db / 4 + 1));
      send_poll(clock_ms, lvl);
      lvl = ~lvl;
    end
  endtask

  // Full press: bounce, settle pressed, hold (short, right at the long-press
  // threshold, or well past it), bounce, settle released.
  task automatic press_cycle();
    int unsigned hold_ms;
    bounce($urandom_range(0, 4));
    hold_level(cur_act, cur_db + $urandom_range(0, 2));
    case ($urandom_range(0, 2))
      0:       hold_ms = $urandom_range(0, cur_lp);
      1:       hold_ms = cur_lp + $urandom_range(0, 2);
      default: hold_ms = cur_lp + $urandom_range(0, 4000);
    endcase
    hold_level(cur_act, hold_ms);
    bounce($urandom_range(0, 4));
    hold_level(~cur_act, cur_db + $urandom_range(0, 2));
  endtask

  // Result sink: random ready gaps, plus one long stall whenever asked.
  initial begin : result_sink
    int unsigned gap;
    int          holds_done;
    out_ready_i = 1'b0;
    holds_done  = 0;
    @(posedge rst_ni);
    forever begin
      if (holds_done != holds_requested) begin
        gap        = SINK_HOLD;
        holds_done = holds_requested;
      end else begin
        gap = pick_gap();
      end
      @(negedge clk_i);
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  initial begin : stimulus
    int   ph;
    int   phase_end;
    int   phase_len;
    logic stalled;
    logic paused;

    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    now_time_i      = '0;
    pin_level_i     = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CFG_ACTIVE_LEVEL;
    cfg_data_i      = '0;
    calm            = 1'b0;
    holds_requested = 0;
    polls_sent      = 0;
    clock_ms        = '0;
    cur_act         = RST_ACTIVE_LEVEL;
    cur_db          = 32'(RST_DEBOUNCE_TIME);
    cur_lp          = 32'(RST_LONG_PRESS_TIME);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // ---- directed: reset settings (pressed = low, 20 ms, 1000 ms) --------
    // Start-up is released; the released level changes nothing.
    send_poll(32'd5, 1'b1);
    send_poll(32'd10, 1'b0);          // change recorded
    send_poll(32'd29, 1'b0);          // one ms short of debounce
    send_poll(32'd30, 1'b0);          // press exactly at debounce
    send_poll(32'd1029, 1'b0);        // one ms short of long press
    send_poll(32'd1030, 1'b0);        // long press
    send_poll(32'd5000, 1'b0);        // long press given only once
    send_poll(32'd5001, 1'b1);
    send_poll(32'd5021, 1'b1);        // release
    // debounce window straddling the timestamp wrap, then long press after it
    send_poll(32'hFFFF_FFF0, 1'b0);
    send_poll(32'd4, 1'b0);
    send_poll(32'd1004, 1'b0);

    // zero debounce, long press disabled
    program_regs(1'b0, 16'd0, 16'd0);
    send_poll(32'd1100, 1'b1);        // released on the same poll
    send_poll(32'd1100, 1'b0);        // pressed on the same poll
    send_poll(32'd70000, 1'b0);       // no long press when disabled

    // long press due, but the release on the same poll wins
    program_regs(1'b0, 16'd0, 16'd1000);
    send_poll(32'd80000, 1'b1);
    send_poll(32'd80000, 1'b0);
    send_poll(32'd81000, 1'b0);

    // flip the active level: state stays, judged against the new level
    program_regs(1'b1, 16'd0, 16'd1000);
    send_poll(32'd81001, 1'b0);
    send_poll(32'd81002, 1'b1);

    // widest debounce and long-press times, hit exactly
    program_regs(1'b0, 16'hFFFF, 16'hFFFF);
    send_poll(32'd81003, 1'b0);
    send_poll(32'd81003 + 32'd65534, 1'b0);
    send_poll(32'd81003 + 32'd65535, 1'b0);
    send_poll(32'd81003 + 32'd131070, 1'b0);

    // ---- random phases, one register setting each ------------------------
    phase_len = RANDOM_POLLS / PHASES;
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: program_regs(1'b0, 16'd20, 16'd1000);
        1: program_regs(1'b1, 16'd0, 16'd0);
        2: program_regs(1'b0, 16'hFFFF, 16'hFFFF);
        3: program_regs(1'b1, 16'd1, 16'd1);
        4: program_regs(1'($urandom), 16'($urandom_range(0, 50)),
                        16'($urandom_range(0, 300)));
        default: program_regs(1'($urandom), 16'($urandom), 16'($urandom));
      endcase
      // half the phases start just below the wrap point
      if ($urandom_range(0, 1) == 1) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 200000);
      else                          clock_ms = $urandom;
      phase_end = polls_sent + phase_len;
      stalled   = 1'b0;
      paused    = 1'b0;
      while (polls_sent < phase_end) begin
        calm = ($urandom_range(0, 7) == 0);
        // midway: the sink stalls while polls keep coming, so input backs up
        if (!stalled && polls_sent + phase_len / 2 >= phase_end) begin
          holds_requested++;
          stalled = 1'b1;
        end
        // late in the phase: hold polls until everything is back
        if (!paused && polls_sent + phase_len / 4 >= phase_end) begin
          settle();
          paused = 1'b1;
        end
        case ($urandom_range(0, 9))
          7, 8: begin
            // cut-short hold that may never be accepted
            hold_level(cur_act ^ 1'($urandom), $urandom_range(0, cur_db));
          end
          9: begin
            // time jumps anywhere, random pin
            repeat ($urandom_range(1, 4)) begin
              clock_ms = $urandom;
              send_poll(clock_ms, 1'($urandom));
            end
          end
          default: press_cycle();
        endcase
      end
    end
    calm = 1'b0;

    settle();
    $display("%0d polls over %0d register settings: bounce, debounce edges, long press,",
             polls_sent, PHASES + 5);
    $display("time wrap, active-level flips and a %0d-cycle sink stall per phase",
             SINK_HOLD);
    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
